/* sv/mant_pkg.sv */
`timescale 1ns / 1ps
// Package for the MIDI active note table: table size, entry layout, cell
// control bundle, codes and the pitch class helper. No dependencies.
package mant_pkg;

   localparam int MAX_NOTES = 16;
   localparam int CNT_W     = $clog2(MAX_NOTES + 1);

   localparam int PITCH_W   = 7;
   localparam int VEL_W     = 7;
   localparam int CLASS_W   = 4;
   localparam int FIELD5_W  = 5;

   // opcode codes carried on req_tuser
   localparam logic OP_NOTE  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   // configuration register indexes
   localparam logic CSR_CLAMP_LO = 1'b0;
   localparam logic CSR_CLAMP_HI = 1'b1;

   // reciprocal of twelve for 7-bit values: q = (p * 43) >> 9, then correct
   localparam int RECIP12_MUL   = 43;
   localparam int RECIP12_SHIFT = 9;

   typedef struct packed {
      logic [VEL_W-1:0]   velocity;
      logic [PITCH_W-1:0] clamped;
      logic [PITCH_W-1:0] orig;
   } note_entry_type;

   typedef struct packed {
      logic load;
      logic mark;
      logic shift;
   } cell_ctl_type;

   function automatic logic [CLASS_W-1:0] pitch_class(input logic [PITCH_W-1:0] p);
      logic [12:0]        prod;
      logic [3:0]         q;
      logic [PITCH_W-1:0] r;
      prod = 13'(p) * 13'(RECIP12_MUL);
      q    = prod[12:RECIP12_SHIFT];
      r    = p - PITCH_W'({q, 3'b000}) - PITCH_W'({q, 2'b00});
      if (r >= PITCH_W'(12)) begin
         r = r - PITCH_W'(12);
      end
      return r[CLASS_W-1:0];
   endfunction

endpackage

/* sv/mant_cell.sv */
`timescale 1ns / 1ps
// One cell of the note chain: holds one entry and its removal mark.
// Depends on mant_pkg.
module mant_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  mant_pkg::cell_ctl_type         ctl,
   input  logic                           in_range,
   input  logic [mant_pkg::CLASS_W-1:0]   event_class,
   input  mant_pkg::note_entry_type       new_entry,
   input  mant_pkg::note_entry_type       next_entry,
   input  logic                           next_mark,
   output mant_pkg::note_entry_type       entry,
   output logic                           mark
);

   mant_pkg::note_entry_type entry_ff;
   logic                     mark_ff;

   // payload: load a new note, or take the upper neighbour's entry
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         entry_ff <= new_entry;
      end else if (ctl.shift) begin
         entry_ff <= next_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff <= 1'b0;
      end else if (ctl.mark) begin
         mark_ff <= in_range && (mant_pkg::pitch_class(entry_ff.orig) == event_class);
      end else if (ctl.shift) begin
         mark_ff <= next_mark;
      end
   end

   assign entry = entry_ff;
   assign mark  = mark_ff;

endmodule

/* sv/midi_active_note_table.sv */
`timescale 1ns / 1ps
// MIDI active note table, top level: mant_cell chain and sequencer, using mant_pkg.
// Note-on and remove-all respond in the cycle after the request; note-off passes
// a mark state, then a compact state with one chain shift per removed note.
// One request at a time; a new request is taken once the sequencer is idle and the
// response register is free or being emptied.
// Reset (synchronous, active high) empties the table and opens the clamp range to 0..127.
module midi_active_note_table (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [6:0] pitch, [13:7] velocity, [15:14] zero
   input  logic        req_tuser,   // [0] opcode
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [4:0] affected_count, [9:5] active_count, [15:10] zero
   output logic        rsp_tuser,   // [0] table_full
   // configuration port
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [6:0]  csr_wdata
);

   localparam int N = mant_pkg::MAX_NOTES;
   localparam int W = mant_pkg::CNT_W;

   // sequencer codes
   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_MARK    = 2'd1;
   localparam logic [1:0] ST_COMPACT = 2'd2;

   logic [1:0]                     state_ff, state_in;
   logic [W-1:0]                   count_ff, count_in;
   logic [W-1:0]                   removed_ff, removed_in;
   logic [mant_pkg::CLASS_W-1:0]   class_ff, class_in;
   logic [mant_pkg::PITCH_W-1:0]   low_ff, high_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [mant_pkg::FIELD5_W-1:0]  rsp_aff_ff, rsp_aff_in;
   logic [mant_pkg::FIELD5_W-1:0]  rsp_act_ff, rsp_act_in;
   logic                           rsp_full_ff, rsp_full_in;

   logic                           req_fire;
   logic                           op;
   logic [mant_pkg::PITCH_W-1:0]   pitch, vel, clip_hi, clamped;
   logic                           full;
   logic                           load_go;
   logic                           any_mark;

   mant_pkg::note_entry_type       new_entry;
   mant_pkg::note_entry_type       cell_entry [N];
   logic [N-1:0]                   cell_mark;
   logic [N-1:0]                   shift_vec;
   mant_pkg::cell_ctl_type         cell_ctl [N];

   assign op    = req_tuser;
   assign pitch = req_tdata[6:0];
   assign vel   = req_tdata[13:7];

   // take a request only when idle and the response register will be free
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   // clamp into range; low wins when it exceeds high
   assign clip_hi = (pitch < high_ff) ? pitch : high_ff;
   assign clamped = (clip_hi > low_ff) ? clip_hi : low_ff;

   assign new_entry = '{velocity: vel, clamped: clamped, orig: pitch};
   assign full      = (count_ff >= W'(N));
   assign load_go   = req_fire && (op == mant_pkg::OP_NOTE) && (vel != '0) && !full;

   // prefix of marks: every cell at or above the lowest marked one shifts down
   always_comb begin
      shift_vec[0] = cell_mark[0];
      for (int i = 1; i < N; i++) begin
         shift_vec[i] = shift_vec[i-1] | cell_mark[i];
      end
   end
   assign any_mark = shift_vec[N-1];

   // the chain of cells
   for (genvar g = 0; g < N; g++) begin : g_cell
      mant_pkg::note_entry_type nxt_entry;
      logic                     nxt_mark;

      if (g == N - 1) begin : g_top
         assign nxt_entry = cell_entry[g];
         assign nxt_mark  = 1'b0;
      end else begin : g_mid
         assign nxt_entry = cell_entry[g+1];
         assign nxt_mark  = cell_mark[g+1];
      end

      assign cell_ctl[g].load  = load_go && (count_ff == W'(g));
      assign cell_ctl[g].mark  = (state_ff == ST_MARK);
      assign cell_ctl[g].shift = (state_ff == ST_COMPACT) && shift_vec[g];

      mant_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (cell_ctl[g]),
         .in_range    (W'(g) < count_ff),
         .event_class (class_ff),
         .new_entry   (new_entry),
         .next_entry  (nxt_entry),
         .next_mark   (nxt_mark),
         .entry       (cell_entry[g]),
         .mark        (cell_mark[g])
      );
   end

   // sequencer and response register
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      removed_in   = removed_ff;
      class_in     = class_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_aff_in   = rsp_aff_ff;
      rsp_act_in   = rsp_act_ff;
      rsp_full_in  = rsp_full_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (op == mant_pkg::OP_CLEAR) begin
                  // remove-all: report the former count
                  count_in     = '0;
                  rsp_valid_in = 1'b1;
                  rsp_aff_in   = mant_pkg::FIELD5_W'(count_ff);
                  rsp_act_in   = '0;
                  rsp_full_in  = 1'b0;
               end else if (vel != '0) begin
                  // note-on: append, or drop and flag when full
                  rsp_valid_in = 1'b1;
                  rsp_full_in  = full;
                  if (full) begin
                     rsp_aff_in = '0;
                     rsp_act_in = mant_pkg::FIELD5_W'(count_ff);
                  end else begin
                     count_in   = count_ff + W'(1);
                     rsp_aff_in = mant_pkg::FIELD5_W'(1);
                     rsp_act_in = mant_pkg::FIELD5_W'(count_ff + W'(1));
                  end
               end else begin
                  // note-off: mark matching cells next cycle, then compact
                  class_in   = mant_pkg::pitch_class(pitch);
                  removed_in = '0;
                  state_in   = ST_MARK;
               end
            end
         end
         ST_MARK: begin
            state_in = ST_COMPACT;
         end
         ST_COMPACT: begin
            if (any_mark) begin
               // drop the lowest marked entry this cycle
               count_in   = count_ff - W'(1);
               removed_in = removed_ff + W'(1);
            end else begin
               rsp_valid_in = 1'b1;
               rsp_aff_in   = mant_pkg::FIELD5_W'(removed_ff);
               rsp_act_in   = mant_pkg::FIELD5_W'(count_ff);
               rsp_full_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      removed_ff  <= removed_in;
      class_ff    <= class_in;
      rsp_aff_ff  <= rsp_aff_in;
      rsp_act_ff  <= rsp_act_in;
      rsp_full_ff <= rsp_full_in;
   end

   // range registers
   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= '0;
         high_ff <= '1;
      end else if (csr_we) begin
         case (csr_index)
            mant_pkg::CSR_CLAMP_LO: low_ff  <= csr_wdata;
            mant_pkg::CSR_CLAMP_HI: high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_act_ff, rsp_aff_ff};
   assign rsp_tuser  = rsp_full_ff;

endmodule

/* sv/mant_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the MIDI active note table, bound to the top level.
// Depends on mant_pkg and midi_active_note_table.
module mant_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // a dropped note adds nothing
   a_full_aff: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[4:0] == 5'd0)
      else $error("dropped note reported as added");

   // a drop happens only with the table at capacity
   a_full_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[9:5] == 5'(mant_pkg::MAX_NOTES))
      else $error("drop flagged below capacity");

   // no response straight after reset
   a_no_early: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response present straight after reset");

endmodule

bind midi_active_note_table mant_checker u_mant_checker (.*);

/* tb/tb_midi_active_note_table.sv */
`timescale 1ns / 1ps
// Self-checking bench for midi_active_note_table: directed and random request streams
// with random idling on both channels, checked against an in-bench model of the table.
// Depends on mant_pkg and the RTL of the block only.
module tb_midi_active_note_table;

   localparam int RUN_LIMIT    = 500000;  // cycles; generous against the slowest correct run
   localparam int LONG_HOLD    = 300;     // cycles the receiver holds off once
   localparam int HOLD_AT      = 150;     // responses seen before that hold-off starts
   localparam int SETTLE_WAIT  = 20;      // cycles allowed after the last response
   localparam int MAX_REPORTED = 10;

   typedef struct {
      logic                         op;
      logic [mant_pkg::PITCH_W-1:0] pitch;
      logic [mant_pkg::VEL_W-1:0]   vel;
   } note_request_type;

   typedef struct packed {
      logic [mant_pkg::FIELD5_W-1:0] affected;
      logic                          full;
      logic [mant_pkg::FIELD5_W-1:0] active;
   } note_reply_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata   = '0;
   logic        req_tuser   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we      = 1'b0;
   logic        csr_index   = mant_pkg::CSR_CLAMP_LO;
   logic [6:0]  csr_wdata   = '0;

   midi_active_note_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Model state: the sounding notes in order, their count and the clamp range.
   mant_pkg::note_entry_type       held_notes [mant_pkg::MAX_NOTES];
   int                             held_count = 0;
   logic [mant_pkg::PITCH_W-1:0]   model_low  = '0;
   logic [mant_pkg::PITCH_W-1:0]   model_high = '1;

   note_request_type     pending_requests [$];
   note_reply_type       expected_replies [$];

   int  mismatch_count = 0;
   int  replies_seen   = 0;
   int  cycle_count    = 0;
   bit  steady_phase   = 1'b0;   // no random idling on either side while set
   bit  long_hold_done = 1'b0;
   int  send_gap       = 0;
   int  recv_stall     = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Apply one request to the model table and return the response it must give.
   function automatic note_reply_type advance_note_table(
         logic op, logic [mant_pkg::PITCH_W-1:0] pitch, logic [mant_pkg::VEL_W-1:0] vel);
      note_reply_type               r;
      logic [mant_pkg::PITCH_W-1:0] clamped;
      int                           kept;
      r = '0;
      if (op == mant_pkg::OP_CLEAR) begin
         r.affected = mant_pkg::FIELD5_W'(held_count);
         held_count = 0;
      end else if (vel != '0) begin
         if (held_count >= mant_pkg::MAX_NOTES) begin
            // full table: drop the note, leave the table alone
            r.full = 1'b1;
         end else begin
            // clamp to high first, then low, so low wins when the range is inverted
            clamped = (pitch < model_high) ? pitch : model_high;
            clamped = (clamped > model_low) ? clamped : model_low;
            held_notes[held_count] = '{velocity: vel, clamped: clamped, orig: pitch};
            held_count++;
            r.affected = 5'd1;
         end
      end else begin
         // note off: drop every note of the same pitch class, keep the others in order
         kept = 0;
         for (int i = 0; i < held_count; i++) begin
            if ((held_notes[i].orig % 12) == (pitch % 12)) begin
               r.affected++;
            end else begin
               held_notes[kept] = held_notes[i];
               kept++;
            end
         end
         held_count = kept;
      end
      r.active = mant_pkg::FIELD5_W'(held_count);
      return r;
   endfunction

   // Idle length, picked from three ranges: mostly the shortest, now and then the longest.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
         return $urandom_range(1, 2);
      end else if (roll < 95) begin
         return $urandom_range(3, 8);
      end
      return $urandom_range(20, 60);
   endfunction

   task automatic push_request(logic op, int pitch, int vel);
      note_request_type queued;
      queued.op    = op;
      queued.pitch = mant_pkg::PITCH_W'(pitch);
      queued.vel   = mant_pkg::VEL_W'(vel);
      pending_requests.insert(pending_requests.size(), queued);
   endtask

   // Write both range registers while the block is idle, keeping the model in step.
   task automatic set_range(int low, int high);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= mant_pkg::CSR_CLAMP_LO;
      csr_wdata <= 7'(low);
      @(posedge clock);
      csr_index <= mant_pkg::CSR_CLAMP_HI;
      csr_wdata <= 7'(high);
      @(posedge clock);
      csr_we    <= 1'b0;
      model_low  = mant_pkg::PITCH_W'(low);
      model_high = mant_pkg::PITCH_W'(high);
   endtask

   // Hold until every request has gone in and every response has come back.
   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pending_requests.size() != 0 || req_tvalid || expected_replies.size() != 0);
   endtask

   // Mostly bursts of note-ons that run the table full, then note-offs and clears,
   // with a share of arbitrary requests as noise.
   task automatic queue_random_phase(int count);
      int pushed;
      int roll;
      int burst;
      pushed = 0;
      while (pushed < count) begin
         roll = $urandom_range(0, 99);
         if (roll < 55) begin
            burst = $urandom_range(1, 18);
            repeat (burst) begin
               case ($urandom_range(0, 9))
                  0:       push_request(mant_pkg::OP_NOTE, $urandom_range(0, 127), 127);
                  1:       push_request(mant_pkg::OP_NOTE, $urandom_range(0, 127), 1);
                  default: push_request(mant_pkg::OP_NOTE, $urandom_range(0, 127),
                                        $urandom_range(1, 127));
               endcase
            end
            pushed += burst;
         end else if (roll < 85) begin
            burst = $urandom_range(1, 4);
            repeat (burst) push_request(mant_pkg::OP_NOTE, $urandom_range(0, 127), 0);
            pushed += burst;
         end else if (roll < 93) begin
            push_request(mant_pkg::OP_CLEAR, $urandom_range(0, 127), $urandom_range(0, 127));
            pushed++;
         end else begin
            push_request(1'($urandom_range(0, 1)), $urandom_range(0, 127),
                         $urandom_range(0, 127));
            pushed++;
         end
      end
   endtask

   // Driver: predict each request at the edge that accepts it, then offer the next.
   always @(posedge clock) begin
      note_request_type item;
      note_reply_type   predicted;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predicted = advance_note_table(req_tuser, req_tdata[6:0], req_tdata[13:7]);
            expected_replies.insert(expected_replies.size(), predicted);
         end
         if (req_tvalid && !req_tready) begin
            // hold the offered request until it is taken
         end else if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            item = pending_requests.pop_front();
            req_tdata  <= {2'b00, item.vel, item.pitch};
            req_tuser  <= item.op;
            req_tvalid <= 1'b1;
            if (!steady_phase && $urandom_range(0, 99) < 30) begin
               send_gap = pick_gap();
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor: check every response against the oldest prediction, then pick rsp_tready.
   always @(posedge clock) begin
      note_reply_type want;
      note_reply_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            replies_seen++;
            got = '{affected: rsp_tdata[4:0], full: rsp_tuser, active: rsp_tdata[9:5]};
            if (expected_replies.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTED) begin
                  $display("unexpected response: affected %0d full %0d active %0d",
                           got.affected, got.full, got.active);
               end
            end else begin
               want = expected_replies.pop_front();
               if (got.affected !== want.affected || got.full !== want.full ||
                   got.active !== want.active) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTED) begin
                     // fields shown as affected/full/active
                     $display("response %0d: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                              replies_seen, want.affected, want.full, want.active,
                              got.affected, got.full, got.active);
                  end
               end
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else if (!long_hold_done && replies_seen >= HOLD_AT) begin
            // hold off long enough for the block to back up and stall its input
            long_hold_done = 1'b1;
            recv_stall = LONG_HOLD;
            rsp_tready <= 1'b0;
         end else if (!steady_phase && $urandom_range(0, 99) < 25) begin
            recv_stall = pick_gap() - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run if it goes on far longer than any correct run could.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= RUN_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Full range: extremes of pitch and velocity, note-off without a match,
      // note-off by pitch class, clear of a non-empty and of an empty table.
      set_range(0, 127);
      push_request(mant_pkg::OP_NOTE, 0, 1);
      push_request(mant_pkg::OP_NOTE, 127, 127);
      push_request(mant_pkg::OP_NOTE, 5, 0);
      push_request(mant_pkg::OP_NOTE, 12, 0);
      push_request(mant_pkg::OP_CLEAR, 127, 127);
      push_request(mant_pkg::OP_CLEAR, 0, 0);
      wait_drained();

      // Inverted range so that low wins; fill the table, overflow it once,
      // then remove two pitch classes and clear what is left.
      set_range(100, 20);
      for (int p = 0; p < mant_pkg::MAX_NOTES; p++) begin
         push_request(mant_pkg::OP_NOTE, p, (p % 2 == 0) ? 1 : 127);
      end
      push_request(mant_pkg::OP_NOTE, 64, 99);
      push_request(mant_pkg::OP_NOTE, 12, 0);
      push_request(mant_pkg::OP_NOTE, 127, 127);
      push_request(mant_pkg::OP_NOTE, 127, 0);
      push_request(mant_pkg::OP_CLEAR, 85, 42);
      wait_drained();

      // Random phases, one range setting each; one phase runs without idling.
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_range(0, 127);
            1: set_range(127, 0);
            2: set_range(0, 0);
            3: set_range(127, 127);
            4: set_range($urandom_range(0, 127), $urandom_range(0, 127));
            default: set_range(35, 90);
         endcase
         steady_phase = (ph == 3);
         queue_random_phase(100);
         // the sender pauses here until every response is back
         wait_drained();
      end

      repeat (SETTLE_WAIT) @(posedge clock);
      if (mismatch_count == 0 && expected_replies.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* files.f */
sv/mant_pkg.sv
sv/mant_cell.sv
sv/midi_active_note_table.sv
sv/mant_checker.sv
tb/tb_midi_active_note_table.sv
